### rtl/miu_pkg.sv
`default_nettype none
package miu_pkg;

    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_UNSUP = 2'd1,
        STAT_SLOT  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        MK_NONE = 3'd0,
        MK_RB   = 3'd1,
        MK_RH   = 3'd2,
        MK_RW   = 3'd3,
        MK_WB   = 3'd4,
        MK_WH   = 3'd5,
        MK_WW   = 3'd6
    } mem_kind_t;

    typedef enum logic [2:0] {
        LX_LB  = 3'd0,
        LX_LH  = 3'd1,
        LX_LW  = 3'd2,
        LX_LBU = 3'd3,
        LX_LHU = 3'd4
    } load_ext_t;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_SLLV = 6'h04;
    localparam logic [5:0] FN_SRLV = 6'h06;
    localparam logic [5:0] FN_SRAV = 6'h07;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    localparam logic [4:0] RI_BLTZ   = 5'h00;
    localparam logic [4:0] RI_BGEZ   = 5'h01;
    localparam logic [4:0] RI_BLTZAL = 5'h10;
    localparam logic [4:0] RI_BGEZAL = 5'h11;

    localparam logic [4:0] REG_RA = 5'd31;

    typedef struct packed {
        logic        mode;
        logic [31:0] word;
        logic [31:0] addr;
        logic [31:0] ldata;
        logic        xfer;
        logic        unsup;
    } item_t;

endpackage
`default_nettype wire

### rtl/mips_integer_execute_unit.sv
// MIPS I integer execute unit.
// Input channel s_*: one transaction per instruction word (s_tuser = 0) or
// per load return (s_tuser = 1). Result channel m_*: exactly one result
// transaction per input transaction, in order.
// Path: an accepted transaction is decoded into the queue, then popped into
// the execute stage with its register file read, then executed into the
// output register that drives m_tvalid.
// Throughput: one transaction per cycle while the receiver is ready; the execute
// stage reads and writes the register file back to back.
// The register file sits in two synchronous rams; per-entry valid bits make
// it read zero after reset, and a write bypass covers a read on the same edge.
// Reset clears the queue, pipeline, branch and load state and all valid bits.
// When the receiver stalls, the output register holds, then the execute
// stage, then the two-entry queue fills and s_tready drops.
`default_nettype none
module mips_integer_execute_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,  // insn_word, insn_addr, load_data
    input  wire logic         s_tuser,  // mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata   // status, next_addr, redirect, mem_kind,
                                        // mem_addr, mem_wdata, zero pad
);
    miu_pkg::item_t item, head;
    logic           full, head_valid, pop;
    logic [1:0]     status;
    logic [31:0]    next_addr, mem_addr, mem_wdata;
    logic           redirect;
    logic [2:0]     mem_kind;

    assign s_tready = !full;

    miu_front u_front (
        .s_mode(s_tuser), .s_word(s_tdata[31:0]), .s_addr(s_tdata[63:32]),
        .s_ldata(s_tdata[95:64]), .item(item)
    );

    miu_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(s_tvalid && !full), .push_item(item),
        .full(full), .pop(pop), .head_valid(head_valid), .head_item(head)
    );

    miu_back u_back (
        .aclk(aclk), .aresetn(aresetn), .head_valid(head_valid), .head_item(head),
        .pop(pop), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_status(status), .out_next_addr(next_addr), .out_redirect(redirect),
        .out_mem_kind(mem_kind), .out_mem_addr(mem_addr), .out_mem_wdata(mem_wdata)
    );

    assign m_tdata = {2'b00, mem_wdata, mem_addr, mem_kind, redirect, next_addr, status};
endmodule
`default_nettype wire

### rtl/miu_ram.sv
`default_nettype none
module miu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

### rtl/miu_front.sv
`default_nettype none
module miu_front (
    input  wire logic        s_mode,
    input  wire logic [31:0] s_word,
    input  wire logic [31:0] s_addr,
    input  wire logic [31:0] s_ldata,
    output miu_pkg::item_t   item
);
    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rt;
    logic       unsup;

    assign op = s_word[31:26];
    assign fn = s_word[5:0];
    assign rt = s_word[20:16];

    always_comb begin
        case (op)
            miu_pkg::OP_SPECIAL: begin
                case (fn)
                    miu_pkg::FN_SLL, miu_pkg::FN_SRL, miu_pkg::FN_SRA,
                    miu_pkg::FN_SLLV, miu_pkg::FN_SRLV, miu_pkg::FN_SRAV,
                    miu_pkg::FN_JR, miu_pkg::FN_JALR, miu_pkg::FN_ADDU,
                    miu_pkg::FN_SUBU, miu_pkg::FN_AND, miu_pkg::FN_OR,
                    miu_pkg::FN_XOR, miu_pkg::FN_NOR, miu_pkg::FN_SLT,
                    miu_pkg::FN_SLTU: unsup = 1'b0;
                    default: unsup = 1'b1;
                endcase
            end
            miu_pkg::OP_REGIMM: begin
                case (rt)
                    miu_pkg::RI_BLTZ, miu_pkg::RI_BGEZ,
                    miu_pkg::RI_BLTZAL, miu_pkg::RI_BGEZAL: unsup = 1'b0;
                    default: unsup = 1'b1;
                endcase
            end
            miu_pkg::OP_J, miu_pkg::OP_JAL, miu_pkg::OP_BEQ, miu_pkg::OP_BNE,
            miu_pkg::OP_BLEZ, miu_pkg::OP_BGTZ, miu_pkg::OP_ADDI, miu_pkg::OP_ADDIU,
            miu_pkg::OP_SLTI, miu_pkg::OP_SLTIU, miu_pkg::OP_ANDI, miu_pkg::OP_ORI,
            miu_pkg::OP_XORI, miu_pkg::OP_LUI, miu_pkg::OP_LB, miu_pkg::OP_LH,
            miu_pkg::OP_LW, miu_pkg::OP_LBU, miu_pkg::OP_LHU, miu_pkg::OP_SB,
            miu_pkg::OP_SH, miu_pkg::OP_SW: unsup = 1'b0;
            default: unsup = 1'b1;
        endcase
    end

    always_comb begin
        item.mode  = s_mode;
        item.word  = s_word;
        item.addr  = s_addr;
        item.ldata = s_ldata;
        // jumps and branches, including the register jumps
        item.xfer  = (op >= miu_pkg::OP_REGIMM && op <= miu_pkg::OP_BGTZ) ||
                     (op == miu_pkg::OP_SPECIAL &&
                      (fn == miu_pkg::FN_JR || fn == miu_pkg::FN_JALR));
        item.unsup = unsup;
    end
endmodule
`default_nettype wire

### rtl/miu_fifo.sv
`default_nettype none
module miu_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire miu_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output miu_pkg::item_t      head_item
);
    localparam int AW = $clog2(miu_pkg::QDEPTH);

    miu_pkg::item_t          mem_reg [miu_pkg::QDEPTH];
    logic [AW-1:0]           wp_reg, wp_next;
    logic [AW-1:0]           rp_reg, rp_next;
    logic [AW:0]             cnt_reg, cnt_next;

    assign full       = (cnt_reg == (AW+1)'(miu_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = mem_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == AW'(miu_pkg::QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop) begin
            rp_next = (rp_reg == AW'(miu_pkg::QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wp_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

### rtl/miu_back.sv
`default_nettype none
module miu_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           head_valid,
    input  wire miu_pkg::item_t head_item,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          out_status,
    output logic [31:0]         out_next_addr,
    output logic                out_redirect,
    output logic [2:0]          out_mem_kind,
    output logic [31:0]         out_mem_addr,
    output logic [31:0]         out_mem_wdata
);
    // execute stage: operands arrive from the register file rams
    logic            b_valid_reg;
    miu_pkg::item_t  b_item_reg;

    logic [31:0]     rf_vld_reg;
    logic            rs_vld_reg, rt_vld_reg;
    logic            byp_v_reg;
    logic [4:0]      byp_a_reg;
    logic [31:0]     byp_d_reg;

    logic            bp_reg, bp_next;
    logic [31:0]     bt_reg, bt_next;
    logic            lp_reg, lp_next;
    logic [4:0]      ld_reg, ld_next;
    logic [2:0]      lx_reg, lx_next;

    logic            ov_reg;
    logic [1:0]      st_reg, st_next;
    logic [31:0]     na_reg, na_next;
    logic            rd_reg, rd_next;
    logic [2:0]      mk_reg, mk_next;
    logic [31:0]     ma_reg, ma_next;
    logic [31:0]     mw_reg, mw_next;

    logic            fire;
    logic            we;
    logic [4:0]      waddr;
    logic [31:0]     wdata;
    logic [31:0]     rdata_a, rdata_b;
    logic [31:0]     a, b;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] imm, simm, ea, pc4, pc8, btgt;

    assign fire = b_valid_reg && (!ov_reg || out_ready);
    assign pop  = head_valid && (!b_valid_reg || fire);

    miu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .re(pop), .raddr(head_item.word[25:21]), .rdata(rdata_a)
    );
    miu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .re(pop), .raddr(head_item.word[20:16]), .rdata(rdata_b)
    );

    assign op   = b_item_reg.word[31:26];
    assign rs   = b_item_reg.word[25:21];
    assign rt   = b_item_reg.word[20:16];
    assign rd   = b_item_reg.word[15:11];
    assign sh   = b_item_reg.word[10:6];
    assign fn   = b_item_reg.word[5:0];
    assign imm  = {16'h0, b_item_reg.word[15:0]};
    assign simm = {{16{b_item_reg.word[15]}}, b_item_reg.word[15:0]};
    assign pc4  = b_item_reg.addr + 32'd4;
    assign pc8  = b_item_reg.addr + 32'd8;
    assign btgt = pc4 + {simm[29:0], 2'b00};

    // a write landing on the same edge as the ram read is missed by the ram
    assign a = (byp_v_reg && byp_a_reg == rs) ? byp_d_reg :
               (rs_vld_reg ? rdata_a : 32'h0);
    assign b = (byp_v_reg && byp_a_reg == rt) ? byp_d_reg :
               (rt_vld_reg ? rdata_b : 32'h0);
    assign ea = a + simm;

    always_comb begin
        logic [31:0] v;
        logic [4:0]  dst;
        logic        wr;
        logic        br;
        logic        tk;
        logic [31:0] tgt;
        v   = '0;
        dst = '0;
        wr  = 1'b0;
        br  = 1'b0;
        tk  = 1'b0;
        tgt = '0;

        bp_next = bp_reg;
        bt_next = bt_reg;
        lp_next = lp_reg;
        ld_next = ld_reg;
        lx_next = lx_reg;
        st_next = miu_pkg::STAT_OK;
        na_next = '0;
        rd_next = 1'b0;
        mk_next = miu_pkg::MK_NONE;
        ma_next = '0;
        mw_next = '0;

        if (b_item_reg.mode) begin
            if (lp_reg) begin
                case (lx_reg)
                    miu_pkg::LX_LB:  v = {{24{b_item_reg.ldata[7]}}, b_item_reg.ldata[7:0]};
                    miu_pkg::LX_LH:  v = {{16{b_item_reg.ldata[15]}}, b_item_reg.ldata[15:0]};
                    miu_pkg::LX_LBU: v = {24'h0, b_item_reg.ldata[7:0]};
                    miu_pkg::LX_LHU: v = {16'h0, b_item_reg.ldata[15:0]};
                    default:         v = b_item_reg.ldata;
                endcase
                dst     = ld_reg;
                wr      = 1'b1;
                lp_next = 1'b0;
            end
        end else begin
            lp_next = 1'b0;
            bp_next = 1'b0;
            na_next = pc4;
            if (bp_reg && b_item_reg.xfer) begin
                st_next = miu_pkg::STAT_SLOT;
            end else if (b_item_reg.unsup) begin
                st_next = miu_pkg::STAT_UNSUP;
            end else begin
                if (bp_reg) begin
                    rd_next = 1'b1;
                    na_next = bt_reg;
                end
                case (op)
                    miu_pkg::OP_SPECIAL: begin
                        dst = rd;
                        wr  = 1'b1;
                        case (fn)
                            miu_pkg::FN_SLL:  v = b << sh;
                            miu_pkg::FN_SRL:  v = b >> sh;
                            miu_pkg::FN_SRA:  v = 32'($signed(b) >>> sh);
                            miu_pkg::FN_SLLV: v = b << a[4:0];
                            miu_pkg::FN_SRLV: v = b >> a[4:0];
                            miu_pkg::FN_SRAV: v = 32'($signed(b) >>> a[4:0]);
                            miu_pkg::FN_JR: begin
                                wr = 1'b0;
                                br = 1'b1;
                                tgt = a;
                            end
                            miu_pkg::FN_JALR: begin
                                br  = 1'b1;
                                tgt = a;
                                v   = pc8;
                                dst = (rd == 5'd0) ? miu_pkg::REG_RA : rd;
                            end
                            miu_pkg::FN_ADDU: v = a + b;
                            miu_pkg::FN_SUBU: v = a - b;
                            miu_pkg::FN_AND:  v = a & b;
                            miu_pkg::FN_OR:   v = a | b;
                            miu_pkg::FN_XOR:  v = a ^ b;
                            miu_pkg::FN_NOR:  v = ~(a | b);
                            miu_pkg::FN_SLT:  v = {31'h0, $signed(a) < $signed(b)};
                            miu_pkg::FN_SLTU: v = {31'h0, a < b};
                            default:          wr = 1'b0;
                        endcase
                    end
                    miu_pkg::OP_REGIMM: begin
                        br  = 1'b1;
                        tk  = a[31] ^ rt[0];
                        tgt = tk ? btgt : pc8;
                        v   = pc8;
                        dst = miu_pkg::REG_RA;
                        wr  = rt[4];
                    end
                    miu_pkg::OP_J, miu_pkg::OP_JAL: begin
                        br  = 1'b1;
                        tgt = {pc4[31:28], b_item_reg.word[25:0], 2'b00};
                        v   = pc8;
                        dst = miu_pkg::REG_RA;
                        wr  = (op == miu_pkg::OP_JAL);
                    end
                    miu_pkg::OP_BEQ, miu_pkg::OP_BNE, miu_pkg::OP_BLEZ,
                    miu_pkg::OP_BGTZ: begin
                        br = 1'b1;
                        case (op)
                            miu_pkg::OP_BEQ:  tk = (a == b);
                            miu_pkg::OP_BNE:  tk = (a != b);
                            miu_pkg::OP_BLEZ: tk = (a == 32'h0) || a[31];
                            default:          tk = (a != 32'h0) && !a[31];
                        endcase
                        tgt = tk ? btgt : pc8;
                    end
                    miu_pkg::OP_ADDI, miu_pkg::OP_ADDIU: begin
                        v = ea; dst = rt; wr = 1'b1;
                    end
                    miu_pkg::OP_SLTI: begin
                        v = {31'h0, $signed(a) < $signed(simm)}; dst = rt; wr = 1'b1;
                    end
                    miu_pkg::OP_SLTIU: begin
                        v = {31'h0, a < simm}; dst = rt; wr = 1'b1;
                    end
                    miu_pkg::OP_ANDI: begin v = a & imm; dst = rt; wr = 1'b1; end
                    miu_pkg::OP_ORI:  begin v = a | imm; dst = rt; wr = 1'b1; end
                    miu_pkg::OP_XORI: begin v = a ^ imm; dst = rt; wr = 1'b1; end
                    miu_pkg::OP_LUI:  begin v = {imm[15:0], 16'h0}; dst = rt; wr = 1'b1; end
                    miu_pkg::OP_LB, miu_pkg::OP_LH, miu_pkg::OP_LW,
                    miu_pkg::OP_LBU, miu_pkg::OP_LHU: begin
                        lp_next = 1'b1;
                        ld_next = rt;
                        ma_next = ea;
                        case (op)
                            miu_pkg::OP_LB: begin
                                lx_next = miu_pkg::LX_LB;  mk_next = miu_pkg::MK_RB;
                            end
                            miu_pkg::OP_LH: begin
                                lx_next = miu_pkg::LX_LH;  mk_next = miu_pkg::MK_RH;
                            end
                            miu_pkg::OP_LW: begin
                                lx_next = miu_pkg::LX_LW;  mk_next = miu_pkg::MK_RW;
                            end
                            miu_pkg::OP_LBU: begin
                                lx_next = miu_pkg::LX_LBU; mk_next = miu_pkg::MK_RB;
                            end
                            default: begin
                                lx_next = miu_pkg::LX_LHU; mk_next = miu_pkg::MK_RH;
                            end
                        endcase
                    end
                    miu_pkg::OP_SB: begin
                        mk_next = miu_pkg::MK_WB; ma_next = ea; mw_next = {24'h0, b[7:0]};
                    end
                    miu_pkg::OP_SH: begin
                        mk_next = miu_pkg::MK_WH; ma_next = ea; mw_next = {16'h0, b[15:0]};
                    end
                    miu_pkg::OP_SW: begin
                        mk_next = miu_pkg::MK_WW; ma_next = ea; mw_next = b;
                    end
                    default: ;
                endcase
                if (br) begin
                    bp_next = 1'b1;
                    bt_next = tgt;
                end
            end
        end

        we    = fire && wr && (dst != 5'd0);
        waddr = dst;
        wdata = v;
    end

    assign out_valid     = ov_reg;
    assign out_status    = st_reg;
    assign out_next_addr = na_reg;
    assign out_redirect  = rd_reg;
    assign out_mem_kind  = mk_reg;
    assign out_mem_addr  = ma_reg;
    assign out_mem_wdata = mw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            ov_reg      <= 1'b0;
            rf_vld_reg  <= '0;
            byp_v_reg   <= 1'b0;
            bp_reg      <= 1'b0;
            bt_reg      <= '0;
            lp_reg      <= 1'b0;
            ld_reg      <= '0;
            lx_reg      <= '0;
        end else begin
            if (pop) begin
                b_valid_reg <= 1'b1;
            end else if (fire) begin
                b_valid_reg <= 1'b0;
            end
            if (fire) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
            if (we) begin
                rf_vld_reg[waddr] <= 1'b1;
            end
            if (pop) begin
                byp_v_reg <= we;
            end
            if (fire) begin
                bp_reg <= bp_next;
                bt_reg <= bt_next;
                lp_reg <= lp_next;
                ld_reg <= ld_next;
                lx_reg <= lx_next;
            end
        end
        if (pop) begin
            b_item_reg <= head_item;
            rs_vld_reg <= rf_vld_reg[head_item.word[25:21]];
            rt_vld_reg <= rf_vld_reg[head_item.word[20:16]];
            byp_a_reg  <= waddr;
            byp_d_reg  <= wdata;
        end
        if (fire) begin
            st_reg <= st_next;
            na_reg <= na_next;
            rd_reg <= rd_next;
            mk_reg <= mk_next;
            ma_reg <= ma_next;
            mw_reg <= mw_next;
        end
    end
endmodule
`default_nettype wire

### rtl/miu_checker.sv
`default_nettype none
module miu_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata
);
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("bad status code");

    a_redirect_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tdata[1:0] == 2'd0 && m_tdata[37:35] != 3'd7)
        else $error("redirect on failed instruction");

    a_no_req_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[37:35] == 3'd0 |-> m_tdata[69:38] == 32'h0 &&
        m_tdata[101:70] == 32'h0)
        else $error("memory fields set without a request");
endmodule

bind mips_integer_execute_unit miu_checker u_miu_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

### sim/mips_integer_execute_unit_tb.sv
`default_nettype none
module mips_integer_execute_unit_tb;

    typedef struct packed {
        miu_pkg::status_t   status;
        logic [31:0]        next_addr;
        logic               redirect;
        miu_pkg::mem_kind_t mem_kind;
        logic [31:0]        mem_addr;
        logic [31:0]        mem_wdata;
    } outcome_t;

    typedef struct {
        logic        mode;
        logic [31:0] word;
        logic [31:0] addr;
        logic [31:0] ldata;
        logic        typed;
        outcome_t    want;
    } vector_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    mips_integer_execute_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow copy of the architectural state
    logic [31:0]        gpr [32];
    logic               jump_held;
    logic [31:0]        jump_dest;
    logic               load_waiting;
    logic [4:0]         load_reg;
    miu_pkg::load_ext_t load_ext;

    outcome_t    pending_results[$];
    vector_t     directed[$];
    int          errors = 0;
    int          sender_idle = 38;
    int          receiver_idle = 76;
    longint      cycles = 0;

    function automatic void put_gpr(logic [4:0] idx, logic [31:0] val);
        if (idx != 5'd0) gpr[idx] = val;
    endfunction

    function automatic logic is_transfer(logic [31:0] w);
        logic [5:0] op;
        logic [5:0] fn;
        op = w[31:26];
        fn = w[5:0];
        if (op >= miu_pkg::OP_REGIMM && op <= miu_pkg::OP_BGTZ) return 1'b1;
        return op == miu_pkg::OP_SPECIAL && (fn == miu_pkg::FN_JR || fn == miu_pkg::FN_JALR);
    endfunction

    function automatic void hold_jump(logic taken, logic [31:0] pc, logic [31:0] simm);
        jump_held = 1'b1;
        jump_dest = taken ? pc + 32'd4 + (simm << 2) : pc + 32'd8;
    endfunction

    // executes one instruction; returns status and fills the memory request
    function automatic miu_pkg::status_t run_insn(logic [31:0] w, logic [31:0] pc,
                                                  ref outcome_t r);
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [31:0] imm;
        logic [31:0] simm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] ea;
        op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6];
        imm = {16'd0, w[15:0]};
        simm = {{16{w[15]}}, w[15:0]};
        a = gpr[rs];
        b = gpr[rt];
        ea = a + simm;
        case (op)
            miu_pkg::OP_SPECIAL: begin
                case (w[5:0])
                    miu_pkg::FN_SLL:  put_gpr(rd, b << sh);
                    miu_pkg::FN_SRL:  put_gpr(rd, b >> sh);
                    miu_pkg::FN_SRA:  put_gpr(rd, $signed(b) >>> sh);
                    miu_pkg::FN_SLLV: put_gpr(rd, b << a[4:0]);
                    miu_pkg::FN_SRLV: put_gpr(rd, b >> a[4:0]);
                    miu_pkg::FN_SRAV: put_gpr(rd, $signed(b) >>> a[4:0]);
                    miu_pkg::FN_JR: begin
                        jump_held = 1'b1; jump_dest = a;
                    end
                    miu_pkg::FN_JALR: begin
                        jump_held = 1'b1; jump_dest = a;
                        put_gpr(rd != 5'd0 ? rd : miu_pkg::REG_RA, pc + 32'd8);
                    end
                    miu_pkg::FN_ADDU: put_gpr(rd, a + b);
                    miu_pkg::FN_SUBU: put_gpr(rd, a - b);
                    miu_pkg::FN_AND:  put_gpr(rd, a & b);
                    miu_pkg::FN_OR:   put_gpr(rd, a | b);
                    miu_pkg::FN_XOR:  put_gpr(rd, a ^ b);
                    miu_pkg::FN_NOR:  put_gpr(rd, ~(a | b));
                    miu_pkg::FN_SLT:  put_gpr(rd, {31'd0, $signed(a) < $signed(b)});
                    miu_pkg::FN_SLTU: put_gpr(rd, {31'd0, a < b});
                    default: return miu_pkg::STAT_UNSUP;
                endcase
            end
            miu_pkg::OP_REGIMM: begin
                case (rt)
                    miu_pkg::RI_BLTZ:   hold_jump(a[31], pc, simm);
                    miu_pkg::RI_BGEZ:   hold_jump(!a[31], pc, simm);
                    miu_pkg::RI_BLTZAL: begin
                        hold_jump(a[31], pc, simm); put_gpr(miu_pkg::REG_RA, pc + 32'd8);
                    end
                    miu_pkg::RI_BGEZAL: begin
                        hold_jump(!a[31], pc, simm); put_gpr(miu_pkg::REG_RA, pc + 32'd8);
                    end
                    default: return miu_pkg::STAT_UNSUP;
                endcase
            end
            miu_pkg::OP_J, miu_pkg::OP_JAL: begin
                jump_held = 1'b1;
                jump_dest = ((pc + 32'd4) & 32'hF000_0000) | {4'd0, w[25:0], 2'b00};
                if (op == miu_pkg::OP_JAL) put_gpr(miu_pkg::REG_RA, pc + 32'd8);
            end
            miu_pkg::OP_BEQ:   hold_jump(a == b, pc, simm);
            miu_pkg::OP_BNE:   hold_jump(a != b, pc, simm);
            miu_pkg::OP_BLEZ:  hold_jump(a == 32'd0 || a[31], pc, simm);
            miu_pkg::OP_BGTZ:  hold_jump(a != 32'd0 && !a[31], pc, simm);
            miu_pkg::OP_ADDI, miu_pkg::OP_ADDIU: put_gpr(rt, a + simm);
            miu_pkg::OP_SLTI:  put_gpr(rt, {31'd0, $signed(a) < $signed(simm)});
            miu_pkg::OP_SLTIU: put_gpr(rt, {31'd0, a < simm});
            miu_pkg::OP_ANDI:  put_gpr(rt, a & imm);
            miu_pkg::OP_ORI:   put_gpr(rt, a | imm);
            miu_pkg::OP_XORI:  put_gpr(rt, a ^ imm);
            miu_pkg::OP_LUI:   put_gpr(rt, imm << 16);
            miu_pkg::OP_LB, miu_pkg::OP_LH, miu_pkg::OP_LW, miu_pkg::OP_LBU,
            miu_pkg::OP_LHU: begin
                load_waiting = 1'b1;
                load_reg = rt;
                case (op)
                    miu_pkg::OP_LB: begin
                        load_ext = miu_pkg::LX_LB;  r.mem_kind = miu_pkg::MK_RB;
                    end
                    miu_pkg::OP_LH: begin
                        load_ext = miu_pkg::LX_LH;  r.mem_kind = miu_pkg::MK_RH;
                    end
                    miu_pkg::OP_LW: begin
                        load_ext = miu_pkg::LX_LW;  r.mem_kind = miu_pkg::MK_RW;
                    end
                    miu_pkg::OP_LBU: begin
                        load_ext = miu_pkg::LX_LBU; r.mem_kind = miu_pkg::MK_RB;
                    end
                    default: begin
                        load_ext = miu_pkg::LX_LHU; r.mem_kind = miu_pkg::MK_RH;
                    end
                endcase
                r.mem_addr = ea;
            end
            miu_pkg::OP_SB: begin
                r.mem_kind = miu_pkg::MK_WB; r.mem_addr = ea; r.mem_wdata = b & 32'hFF;
            end
            miu_pkg::OP_SH: begin
                r.mem_kind = miu_pkg::MK_WH; r.mem_addr = ea; r.mem_wdata = b & 32'hFFFF;
            end
            miu_pkg::OP_SW: begin
                r.mem_kind = miu_pkg::MK_WW; r.mem_addr = ea; r.mem_wdata = b;
            end
            default: return miu_pkg::STAT_UNSUP;
        endcase
        return miu_pkg::STAT_OK;
    endfunction

    function automatic outcome_t execute_item(logic mode, logic [31:0] w, logic [31:0] pc,
                                              logic [31:0] d);
        outcome_t    r;
        logic        in_slot;
        logic [31:0] held;
        logic [31:0] v;
        r = '{status: miu_pkg::STAT_OK, mem_kind: miu_pkg::MK_NONE, default: '0};
        if (mode) begin
            if (load_waiting) begin
                case (load_ext)
                    miu_pkg::LX_LB:  v = {{24{d[7]}}, d[7:0]};
                    miu_pkg::LX_LH:  v = {{16{d[15]}}, d[15:0]};
                    miu_pkg::LX_LBU: v = {24'd0, d[7:0]};
                    miu_pkg::LX_LHU: v = {16'd0, d[15:0]};
                    default:         v = d;
                endcase
                put_gpr(load_reg, v);
                load_waiting = 1'b0;
            end
            return r;
        end
        in_slot = jump_held;
        held = jump_dest;
        load_waiting = 1'b0;
        jump_held = 1'b0;
        r.next_addr = pc + 32'd4;
        if (in_slot && is_transfer(w)) begin
            r.status = miu_pkg::STAT_SLOT;
        end else begin
            r.status = run_insn(w, pc, r);
            if (r.status != miu_pkg::STAT_OK) begin
                r.mem_kind = miu_pkg::MK_NONE; r.mem_addr = '0; r.mem_wdata = '0;
            end else if (in_slot) begin
                r.redirect = 1'b1;
                r.next_addr = held;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] enc_r(int rs, int rt, int rd, int sh, logic [5:0] fn);
        return {miu_pkg::OP_SPECIAL, 5'(rs), 5'(rt), 5'(rd), 5'(sh), fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, int rs, int rt, logic [15:0] imm);
        return {op, 5'(rs), 5'(rt), imm};
    endfunction

    function automatic logic [31:0] random_insn();
        logic [5:0] fns [16] = '{miu_pkg::FN_SLL, miu_pkg::FN_SRL, miu_pkg::FN_SRA,
                                 miu_pkg::FN_SLLV, miu_pkg::FN_SRLV, miu_pkg::FN_SRAV,
                                 miu_pkg::FN_JR, miu_pkg::FN_JALR, miu_pkg::FN_ADDU,
                                 miu_pkg::FN_SUBU, miu_pkg::FN_AND, miu_pkg::FN_OR,
                                 miu_pkg::FN_XOR, miu_pkg::FN_NOR, miu_pkg::FN_SLT,
                                 miu_pkg::FN_SLTU};
        logic [5:0] ops [22] = '{miu_pkg::OP_J, miu_pkg::OP_JAL, miu_pkg::OP_BEQ,
                                 miu_pkg::OP_BNE, miu_pkg::OP_BLEZ, miu_pkg::OP_BGTZ,
                                 miu_pkg::OP_ADDI, miu_pkg::OP_ADDIU, miu_pkg::OP_SLTI,
                                 miu_pkg::OP_SLTIU, miu_pkg::OP_ANDI, miu_pkg::OP_ORI,
                                 miu_pkg::OP_XORI, miu_pkg::OP_LUI, miu_pkg::OP_LB,
                                 miu_pkg::OP_LH, miu_pkg::OP_LW, miu_pkg::OP_LBU,
                                 miu_pkg::OP_LHU, miu_pkg::OP_SB, miu_pkg::OP_SH,
                                 miu_pkg::OP_SW};
        logic [4:0] ris [4] = '{miu_pkg::RI_BLTZ, miu_pkg::RI_BGEZ, miu_pkg::RI_BLTZAL,
                                miu_pkg::RI_BGEZAL};
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: w[31:26] = miu_pkg::OP_SPECIAL;
            4: begin
                w[31:26] = miu_pkg::OP_REGIMM; w[20:16] = ris[$urandom_range(3)];
            end
            default:    w[31:26] = ops[$urandom_range(21)];
        endcase
        if (w[31:26] == miu_pkg::OP_SPECIAL) w[5:0] = fns[$urandom_range(15)];
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    endtask

    // drive one transaction, book its expected result on acceptance
    task automatic send(logic mode, logic [31:0] w, logic [31:0] pc, logic [31:0] d,
                        logic typed, outcome_t want);
        outcome_t r;
        while ($urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {d, pc, w};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = execute_item(mode, w, pc, d);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic send_plain(logic mode, logic [31:0] w, logic [31:0] pc, logic [31:0] d);
        send(mode, w, pc, d, 1'b0, '0);
    endtask

    task automatic add_row(logic mode, logic [31:0] w, logic [31:0] pc, logic [31:0] d,
                           logic typed, outcome_t want);
        directed.push_back('{mode, w, pc, d, typed, want});
    endtask

    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        cycles <= cycles + 1;
        m_tready <= aresetn && ($urandom_range(99) >= receiver_idle);
        if (m_tvalid && m_tready) begin
            got = m_tdata[101:0];
            got.status    = miu_pkg::status_t'(m_tdata[1:0]);
            got.next_addr = m_tdata[33:2];
            got.redirect  = m_tdata[34];
            got.mem_kind  = miu_pkg::mem_kind_t'(m_tdata[37:35]);
            got.mem_addr  = m_tdata[69:38];
            got.mem_wdata = m_tdata[101:70];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.next_addr != want.next_addr)
                    report_mismatch("next_addr", got.next_addr, want.next_addr);
                if (got.redirect != want.redirect)
                    report_mismatch("redirect", got.redirect, want.redirect);
                if (got.mem_kind != want.mem_kind)
                    report_mismatch("mem_kind", got.mem_kind, want.mem_kind);
                if (got.mem_addr != want.mem_addr)
                    report_mismatch("mem_addr", got.mem_addr, want.mem_addr);
                if (got.mem_wdata != want.mem_wdata)
                    report_mismatch("mem_wdata", got.mem_wdata, want.mem_wdata);
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        outcome_t    zero;
        logic [31:0] w;
        logic [31:0] pc;
        int          sent;
        int          pick;
        logic        drained;
        zero = '{status: miu_pkg::STAT_OK, mem_kind: miu_pkg::MK_NONE, default: '0};
        foreach (gpr[i]) gpr[i] = '0;
        jump_held = 1'b0; jump_dest = '0;
        load_waiting = 1'b0; load_reg = '0; load_ext = miu_pkg::LX_LB;

        // load return with nothing outstanding after reset: all fields zero
        add_row(1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, zero);
        add_row(1'b0, enc_i(miu_pkg::OP_ADDIU, 0, 1, 16'hFFFF), 32'h0, 32'd0, 1'b0, zero);
        add_row(1'b0, enc_i(miu_pkg::OP_LUI, 0, 2, 16'h8000), 32'h4, 32'd0, 1'b0, zero);
        add_row(1'b0, enc_r(0, 2, 3, 31, miu_pkg::FN_SRA), 32'h8, 32'd0, 1'b0, zero);
        add_row(1'b0, enc_r(2, 1, 4, 0, miu_pkg::FN_SLTU), 32'hC, 32'd0, 1'b0, zero);
        // addi wraps silently
        add_row(1'b0, enc_i(miu_pkg::OP_ADDI, 2, 5, 16'hFFFF), 32'h10, 32'd0, 1'b0, zero);
        add_row(1'b0, enc_r(0, 0, 6, 0, miu_pkg::FN_NOR), 32'h14, 32'd0, 1'b0, zero);
        add_row(1'b0, enc_i(miu_pkg::OP_LB, 1, 7, 16'h0000), 32'h18, 32'd0, 1'b0, zero);
        add_row(1'b1, 32'd0, 32'd0, 32'h0000_0080, 1'b0, zero);
        add_row(1'b0, enc_i(miu_pkg::OP_LHU, 0, 8, 16'h0002), 32'h1C, 32'd0, 1'b0, zero);
        // load abandoned by the next instruction, its data then ignored
        add_row(1'b0, enc_i(miu_pkg::OP_LW, 0, 9, 16'h0000), 32'h20, 32'd0, 1'b0, zero);
        add_row(1'b0, enc_i(miu_pkg::OP_SW, 0, 1, 16'hFFFC), 32'h24, 32'd0, 1'b0, zero);
        add_row(1'b1, 32'd0, 32'd0, 32'h1234_5678, 1'b1, zero);
        add_row(1'b0, enc_i(miu_pkg::OP_SB, 2, 1, 16'h0000), 32'h28, 32'd0, 1'b0, zero);
        add_row(1'b0, enc_i(miu_pkg::OP_BEQ, 0, 0, 16'hFFFF), 32'h100, 32'd0, 1'b0, zero);
        add_row(1'b0, enc_r(1, 2, 10, 0, miu_pkg::FN_ADDU), 32'h104, 32'd0, 1'b0, zero);
        // jalr with rd zero links into ra
        add_row(1'b0, enc_r(1, 0, 0, 0, miu_pkg::FN_JALR), 32'h200, 32'd0, 1'b0, zero);
        add_row(1'b0, {miu_pkg::OP_J, 26'h3FF_FFFF}, 32'h204, 32'd0, 1'b1,
                '{status: miu_pkg::STAT_SLOT, next_addr: 32'h208,
                  mem_kind: miu_pkg::MK_NONE, default: '0});
        add_row(1'b0, {miu_pkg::OP_JAL, 26'h3FF_FFFF}, 32'hFFFF_FFF0, 32'd0, 1'b0, zero);
        add_row(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFF4, 32'd0, 1'b1,
                '{status: miu_pkg::STAT_UNSUP, next_addr: 32'hFFFF_FFF8,
                  mem_kind: miu_pkg::MK_NONE, default: '0});
        add_row(1'b0, enc_i(miu_pkg::OP_REGIMM, 0, miu_pkg::RI_BGEZAL, 16'h7FFF), 32'h300,
                32'd0, 1'b0, zero);
        add_row(1'b0, enc_i(miu_pkg::OP_SH, 6, 6, 16'h0000), 32'h304, 32'd0, 1'b0, zero);
        add_row(1'b0, enc_i(miu_pkg::OP_REGIMM, 0, 5'h02, 16'h0000), 32'h308, 32'd0, 1'b1,
                '{status: miu_pkg::STAT_UNSUP, next_addr: 32'h30C,
                  mem_kind: miu_pkg::MK_NONE, default: '0});
        add_row(1'b0, enc_r(1, 2, 11, 0, miu_pkg::FN_SRLV), 32'h30C, 32'd0, 1'b0, zero);
        add_row(1'b0, enc_r(1, 2, 12, 0, miu_pkg::FN_SLLV), 32'h310, 32'd0, 1'b0, zero);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send(directed[i].mode, directed[i].word, directed[i].addr, directed[i].ldata,
                 directed[i].typed, directed[i].want);

        sent = 0;
        drained = 1'b0;
        pc = $urandom;
        while (sent < 600) begin
            if (sent >= 400) begin
                sender_idle = 0; receiver_idle = 0;
            end else if (sent >= 200) begin
                sender_idle = 76; receiver_idle = 38;
            end
            // hold off until the block has drained
            if (sent >= 300 && !drained) begin
                drained = 1'b1;
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            pick = $urandom_range(99);
            if (pick < 5) begin
                // stray load data
                send_plain(1'b1, $urandom, $urandom, $urandom);
            end else begin
                w = (pick < 10) ? $urandom : random_insn();
                send_plain(1'b0, w, pc, 32'd0);
                sent++;
                if (w[31:26] >= miu_pkg::OP_LB && w[31:26] <= miu_pkg::OP_LHU &&
                    $urandom_range(9) < 8) begin
                    send_plain(1'b1, $urandom, $urandom, $urandom);
                    sent++;
                end
                pc = ($urandom_range(7) == 0) ? $urandom : pc + 32'd4;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
rtl/miu_pkg.sv
rtl/miu_ram.sv
rtl/miu_front.sv
rtl/miu_fifo.sv
rtl/miu_back.sv
rtl/mips_integer_execute_unit.sv
rtl/miu_checker.sv
sim/mips_integer_execute_unit_tb.sv
